/* hdl/rsi_pkg.sv */
// Shared types and constants for the ray / sphere intersection unit.
`timescale 1ns / 1ps
package rsi_pkg;

    localparam int WORD_BITS     = 32;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

    typedef struct packed {
        logic signed [WORD_BITS-1:0] origin_x;
        logic signed [WORD_BITS-1:0] origin_y;
        logic signed [WORD_BITS-1:0] origin_z;
        logic signed [WORD_BITS-1:0] dir_x;
        logic signed [WORD_BITS-1:0] dir_y;
        logic signed [WORD_BITS-1:0] dir_z;
        logic signed [WORD_BITS-1:0] center_x;
        logic signed [WORD_BITS-1:0] center_y;
        logic signed [WORD_BITS-1:0] center_z;
        logic        [WORD_BITS-2:0] sphere_radius;
    } rsi_in_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] hit_distance;
        logic                        is_hit;
    } rsi_out_t;

endpackage

/* hdl/rsi_wmul.sv */
// Two-stage signed multiplier built from four half-width partial products.
`timescale 1ns / 1ps
module rsi_wmul #(
    parameter int AW = 66,
    parameter int BW = 66
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_vld,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic                    out_vld,
    output logic signed [AW+BW-1:0] p
);
    localparam int LA = AW / 2;
    localparam int LB = BW / 2;
    localparam int HA = AW - LA;
    localparam int HB = BW - LB;
    localparam int PW = AW + BW;

    logic        [LA-1:0] al;
    logic signed [HA-1:0] ah;
    logic        [LB-1:0] bl;
    logic signed [HB-1:0] bh;

    logic               vld1_reg, vld2_reg;
    logic [LA+LB-1:0]   pll_reg, pll_next;
    logic signed [HA+LB:0]    phl_reg, phl_next;
    logic signed [LA+HB:0]    plh_reg, plh_next;
    logic signed [HA+HB-1:0]  phh_reg, phh_next;
    logic signed [PW-1:0]     p_reg, p_next;

    assign al = a[LA-1:0];
    assign ah = a[AW-1:LA];
    assign bl = b[LB-1:0];
    assign bh = b[BW-1:LB];

    always_comb
    begin
        pll_next = al * bl;
        phl_next = ah * $signed({1'b0, bl});
        plh_next = $signed({1'b0, al}) * bh;
        phh_next = ah * bh;
        p_next   = (PW'(phh_reg) <<< (LA + LB)) + (PW'(phl_reg) <<< LA)
                 + (PW'(plh_reg) <<< LB) + PW'(pll_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pll_reg <= pll_next;
            phl_reg <= phl_next;
            plh_reg <= plh_next;
            phh_reg <= phh_next;
            p_reg   <= p_next;
        end
    end

    assign out_vld = vld2_reg;
    assign p       = p_reg;

endmodule

/* hdl/rsi_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module rsi_sqrt #(
    parameter int XW  = 164,
    parameter int SBW = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [XW-1:0]     x,
    input  logic [SBW-1:0]    in_sb,
    output logic              out_vld,
    output logic [XW/2-1:0]   root,
    output logic [SBW-1:0]    out_sb
);
    localparam int RW   = XW / 2;
    localparam int REMW = RW + 3;

    logic             vld_s  [0:RW];
    logic [REMW-1:0]  rem_s  [0:RW];
    logic [RW-1:0]    root_s [0:RW];
    logic [XW-1:0]    x_s    [0:RW];
    logic [SBW-1:0]   sb_s   [0:RW];

    assign vld_s[0]  = in_vld;
    assign rem_s[0]  = '0;
    assign root_s[0] = '0;
    assign x_s[0]    = x;
    assign sb_s[0]   = in_sb;

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        logic [REMW-1:0] cat, trial;
        logic            vld_reg;
        logic [REMW-1:0] rem_reg, rem_next;
        logic [RW-1:0]   root_reg, root_next;
        logic [XW-1:0]   x_reg, x_next;
        logic [SBW-1:0]  sb_reg;

        always_comb
        begin
            cat   = {rem_s[k][REMW-3:0], x_s[k][XW-1 -: 2]};
            trial = REMW'({root_s[k], 2'b01});
            if (cat >= trial)
            begin
                rem_next  = cat - trial;
                root_next = {root_s[k][RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = cat;
                root_next = {root_s[k][RW-2:0], 1'b0};
            end
            x_next = x_s[k] << 2;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld_s[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                x_reg    <= x_next;
                sb_reg   <= sb_s[k];
            end
        end

        assign vld_s[k+1]  = vld_reg;
        assign rem_s[k+1]  = rem_reg;
        assign root_s[k+1] = root_reg;
        assign x_s[k+1]    = x_reg;
        assign sb_s[k+1]   = sb_reg;
    end

    assign out_vld = vld_s[RW];
    assign root    = root_s[RW];
    assign out_sb  = sb_s[RW];

endmodule

/* hdl/rsi_div.sv */
// Pipelined restoring unsigned divider, one quotient bit per stage.
`timescale 1ns / 1ps
module rsi_div #(
    parameter int NW  = 84,
    parameter int DW  = 64,
    parameter int SBW = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  logic [NW-1:0]   num,
    input  logic [DW-1:0]   den,
    input  logic [SBW-1:0]  in_sb,
    output logic            out_vld,
    output logic [NW-1:0]   quo,
    output logic [SBW-1:0]  out_sb
);
    logic            vld_s [0:NW];
    logic [DW-1:0]   rem_s [0:NW];
    logic [NW-1:0]   num_s [0:NW];
    logic [NW-1:0]   quo_s [0:NW];
    logic [DW-1:0]   den_s [0:NW];
    logic [SBW-1:0]  sb_s  [0:NW];

    assign vld_s[0] = in_vld;
    assign rem_s[0] = '0;
    assign num_s[0] = num;
    assign quo_s[0] = '0;
    assign den_s[0] = den;
    assign sb_s[0]  = in_sb;

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic [DW:0]     cat;
        logic [DW-1:0]   diff;
        logic            vld_reg;
        logic [DW-1:0]   rem_reg, rem_next;
        logic [NW-1:0]   num_reg, num_next;
        logic [NW-1:0]   quo_reg, quo_next;
        logic [DW-1:0]   den_reg;
        logic [SBW-1:0]  sb_reg;

        always_comb
        begin
            cat  = {rem_s[k], num_s[k][NW-1]};
            diff = cat[DW-1:0] - den_s[k];
            if (cat >= {1'b0, den_s[k]})
            begin
                rem_next = diff;
                quo_next = {quo_s[k][NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = cat[DW-1:0];
                quo_next = {quo_s[k][NW-2:0], 1'b0};
            end
            num_next = num_s[k] << 1;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld_s[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= rem_next;
                num_reg <= num_next;
                quo_reg <= quo_next;
                den_reg <= den_s[k];
                sb_reg  <= sb_s[k];
            end
        end

        assign vld_s[k+1] = vld_reg;
        assign rem_s[k+1] = rem_reg;
        assign num_s[k+1] = num_reg;
        assign quo_s[k+1] = quo_reg;
        assign den_s[k+1] = den_reg;
        assign sb_s[k+1]  = sb_reg;
    end

    assign out_vld = vld_s[NW];
    assign quo     = quo_s[NW];
    assign out_sb  = sb_s[NW];

endmodule

/* hdl/ray_sphere_intersect.sv */
// Top level of the pipelined ray / sphere intersection unit.
// Takes one ray and sphere per clock while ray_stall is low and returns
// whether the ray's line meets the sphere and the ray parameter of the nearer
// root, Q(WORD_BITS-FRAC_BITS).FRAC_BITS, Q16.16 by default. A miss (negative
// discriminant or zero direction) gives is_hit = 0 and -1.0; a root out of
// range saturates with is_hit = 1. Throughput is one transfer per cycle while
// ray_stall is low. The path runs through RW = 2*WORD_BITS + 2 + FRAC_BITS square
// root stages, one root bit each, and NW = 2*WORD_BITS + 4 + FRAC_BITS divider
// stages, one quotient bit each. The whole pipeline moves on one enable; a result
// waiting on hit goes to a one-entry skid register, and only once that is also
// full is ray_stall raised.
`timescale 1ns / 1ps
module ray_sphere_intersect #(
    parameter int FRAC_BITS = rsi_pkg::DEF_FRAC_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             ray_valid,
    output logic             ray_stall,
    input  rsi_pkg::rsi_in_t ray_data,
    output logic             hit_valid,
    input  logic             hit_stall,
    output rsi_pkg::rsi_out_t hit_data
);
    import rsi_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int OCW = W + 1;            // origin - center
    localparam int AW  = 2 * W;            // a = d.d, unsigned
    localparam int HW  = 2 * W + 2;        // h = oc.d (b/2)
    localparam int CW  = 2 * W + 3;        // c = oc.oc - r^2
    localparam int QW  = 4 * W + 4;        // h^2 - a c (disc/4)
    localparam int XW  = 4 * W + 4 + 2 * FRAC_BITS;
    localparam int RW  = XW / 2;
    localparam int NW  = 2 * W + 4 + FRAC_BITS;
    localparam int SQB = 1 + AW + HW;

    localparam logic signed [W-1:0] MISS_DIST = ~((W'(1) << FRAC_BITS) - W'(1));
    localparam logic [NW-1:0] NEG_LIM = NW'(1) << (W - 1);
    localparam logic [NW-1:0] POS_LIM = NEG_LIM - NW'(1);

    // global advance: the pipeline only freezes once the skid register is full
    logic en;
    logic skid_full_reg, skid_full_next;
    assign en = !skid_full_reg;

    // stage 1: oc = origin - center, capture direction and radius
    logic signed [W-1:0]   o_in [3];
    logic signed [W-1:0]   d_in [3];
    logic signed [W-1:0]   c_in [3];
    logic                  v1_reg;
    logic signed [OCW-1:0] oc_reg [3], oc_next [3];
    logic signed [W-1:0]   d_reg  [3];
    logic [W-2:0]          r_reg;

    assign o_in[0] = ray_data.origin_x;
    assign o_in[1] = ray_data.origin_y;
    assign o_in[2] = ray_data.origin_z;
    assign d_in[0] = ray_data.dir_x;
    assign d_in[1] = ray_data.dir_y;
    assign d_in[2] = ray_data.dir_z;
    assign c_in[0] = ray_data.center_x;
    assign c_in[1] = ray_data.center_y;
    assign c_in[2] = ray_data.center_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            oc_next[k] = o_in[k] - c_in[k];
    end

    // stage 2: per-axis products
    logic                  v2_reg;
    logic [AW-1:0]         dd_reg   [3], dd_next   [3];
    logic signed [2*W:0]   ocd_reg  [3], ocd_next  [3];
    logic signed [2*W+1:0] ococ_reg [3], ococ_next [3];
    logic [2*W-3:0]        rr_reg, rr_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dd_next[k]   = d_reg[k] * d_reg[k];
            ocd_next[k]  = oc_reg[k] * d_reg[k];
            ococ_next[k] = oc_reg[k] * oc_reg[k];
        end
        rr_next = r_reg * r_reg;
    end

    // stage 3: quadratic coefficients
    logic                 v3_reg;
    logic [AW-1:0]        a_reg, a_next;
    logic signed [HW-1:0] h_reg, h_next;
    logic signed [CW-1:0] c_reg, c_next;

    always_comb
    begin
        a_next = dd_reg[0] + dd_reg[1] + dd_reg[2];
        h_next = HW'(ocd_reg[0]) + HW'(ocd_reg[1]) + HW'(ocd_reg[2]);
        c_next = CW'(ococ_reg[0]) + CW'(ococ_reg[1]) + CW'(ococ_reg[2]) - CW'(rr_reg);
    end

    // stages 4-5: h^2 and a c
    logic                 hh_vld, ac_vld, v5;
    logic signed [QW-1:0] hh, ac;
    logic [AW-1:0]        a4_reg, a5_reg;
    logic signed [HW-1:0] h4_reg, h5_reg;

    rsi_wmul #(.AW(HW), .BW(HW)) u_mul_hh (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (v3_reg),
        .a       (h_reg),
        .b       (h_reg),
        .out_vld (hh_vld),
        .p       (hh)
    );

    rsi_wmul #(.AW(AW + 1), .BW(CW)) u_mul_ac (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (v3_reg),
        .a       ($signed({1'b0, a_reg})),
        .b       (c_reg),
        .out_vld (ac_vld),
        .p       (ac)
    );

    assign v5 = hh_vld & ac_vld;

    // stage 6: quarter discriminant, miss decision, root operand
    logic signed [QW-1:0] q;
    logic                 v6_reg;
    logic                 m6_reg, m6_next;
    logic [XW-1:0]        x6_reg, x6_next;
    logic [AW-1:0]        a6_reg;
    logic signed [HW-1:0] h6_reg;

    always_comb
    begin
        q       = hh - ac;
        m6_next = (a5_reg == '0) || q[QW-1];
        x6_next = m6_next ? '0 : (XW'(q[QW-2:0]) << (2 * FRAC_BITS));
    end

    // square root of disc/4 scaled by 2^(2 FRAC_BITS)
    logic                 sq_vld;
    logic [RW-1:0]        s;
    logic [SQB-1:0]       sq_sb;
    logic                 m_sq;
    logic [AW-1:0]        a_sq;
    logic signed [HW-1:0] h_sq;

    rsi_sqrt #(.XW(XW), .SBW(SQB)) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (v6_reg),
        .x       (x6_reg),
        .in_sb   ({m6_reg, a6_reg, h6_reg}),
        .out_vld (sq_vld),
        .root    (s),
        .out_sb  (sq_sb)
    );

    assign m_sq = sq_sb[SQB-1];
    assign a_sq = sq_sb[HW +: AW];
    assign h_sq = $signed(sq_sb[HW-1:0]);

    // stage 7: numerator -h 2^F - s
    logic                 v7_reg, m7_reg;
    logic [AW-1:0]        a7_reg;
    logic signed [NW-1:0] n7_reg, n7_next;

    assign n7_next = -(NW'(h_sq) <<< FRAC_BITS) - NW'(s);

    // stage 8: magnitude for the floor quotient (|n| + a - 1 when negative)
    logic [NW-1:0]        nm;
    logic                 v8_reg, m8_reg, g8_reg;
    logic [AW-1:0]        a8_reg;
    logic [NW-1:0]        num8_reg, num8_next;

    always_comb
    begin
        nm        = NW'(a7_reg) - NW'(1) - NW'(n7_reg);
        num8_next = n7_reg[NW-1] ? nm : n7_reg;
    end

    // divider
    logic          dv_vld;
    logic [NW-1:0] quo;
    logic [1:0]    dv_sb;

    rsi_div #(.NW(NW), .DW(AW), .SBW(2)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (v8_reg),
        .num     (num8_reg),
        .den     (a8_reg),
        .in_sb   ({m8_reg, g8_reg}),
        .out_vld (dv_vld),
        .quo     (quo),
        .out_sb  (dv_sb)
    );

    // stage 9: sign, saturation and miss value
    logic     v9_reg;
    rsi_out_t res_reg, res_next;

    always_comb
    begin
        res_next.is_hit = !dv_sb[1];
        if (dv_sb[1])
            res_next.hit_distance = MISS_DIST;
        else if (dv_sb[0])
            res_next.hit_distance = (quo > NEG_LIM) ? WORD_MIN : -$signed(quo[W-1:0]);
        else
            res_next.hit_distance = (quo > POS_LIM) ? WORD_MAX : $signed(quo[W-1:0]);
    end

    // output register plus skid register
    logic     take;
    logic     out_vld_reg, out_vld_next;
    rsi_out_t out_reg, out_next;
    rsi_out_t skid_reg, skid_next;

    assign take = out_vld_reg && !hit_stall;

    always_comb
    begin
        out_vld_next   = out_vld_reg;
        out_next       = out_reg;
        skid_full_next = skid_full_reg;
        skid_next      = skid_reg;
        if (skid_full_reg)
        begin
            if (take)
            begin
                out_next       = skid_reg;
                skid_full_next = 1'b0;
            end
        end
        else if (!out_vld_reg || take)
        begin
            out_vld_next = v9_reg;
            out_next     = res_reg;
        end
        else if (v9_reg)
        begin
            skid_next      = res_reg;
            skid_full_next = 1'b1;
        end
    end

    // valid chain and handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            out_vld_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                v1_reg <= ray_valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v6_reg <= v5;
                v7_reg <= sq_vld;
                v8_reg <= v7_reg;
                v9_reg <= dv_vld;
            end
            out_vld_reg   <= out_vld_next;
            skid_full_reg <= skid_full_next;
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                oc_reg[k]   <= oc_next[k];
                d_reg[k]    <= d_in[k];
                dd_reg[k]   <= dd_next[k];
                ocd_reg[k]  <= ocd_next[k];
                ococ_reg[k] <= ococ_next[k];
            end
            r_reg    <= ray_data.sphere_radius;
            rr_reg   <= rr_next;
            a_reg    <= a_next;
            h_reg    <= h_next;
            c_reg    <= c_next;
            a4_reg   <= a_reg;
            h4_reg   <= h_reg;
            a5_reg   <= a4_reg;
            h5_reg   <= h4_reg;
            m6_reg   <= m6_next;
            x6_reg   <= x6_next;
            a6_reg   <= a5_reg;
            h6_reg   <= h5_reg;
            m7_reg   <= m_sq;
            a7_reg   <= a_sq;
            n7_reg   <= n7_next;
            m8_reg   <= m7_reg;
            g8_reg   <= n7_reg[NW-1];
            a8_reg   <= a7_reg;
            num8_reg <= num8_next;
            res_reg  <= res_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign ray_stall = skid_full_reg;
    assign hit_valid = out_vld_reg;
    assign hit_data  = out_reg;

endmodule

/* hdl/rsi_checker.sv */
// Port-level checker for the intersection unit, bound to the top level.
`timescale 1ns / 1ps
module rsi_checker #(
    parameter int FRAC_BITS = rsi_pkg::DEF_FRAC_BITS
) (
    input logic              clk,
    input logic              rst_n,
    input logic              ray_stall,
    input logic              hit_valid,
    input logic              hit_stall,
    input rsi_pkg::rsi_out_t hit_data
);
    import rsi_pkg::*;

    localparam logic signed [WORD_BITS-1:0] MISS_DIST =
        ~((WORD_BITS'(1) << FRAC_BITS) - WORD_BITS'(1));

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && hit_stall |=> hit_valid && $stable(hit_data))
        else $error("result changed while stalled");

    // every miss carries -1.0
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && !hit_data.is_hit |-> hit_data.hit_distance == MISS_DIST)
        else $error("miss without -1.0 distance");

    // input back-pressure only while a result is pending
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ray_stall |-> hit_valid)
        else $error("ray_stall with no result pending");

    // back-pressure comes only from a stalled result
    a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ray_stall) |-> $past(hit_valid && hit_stall))
        else $error("ray_stall rose without a stalled result");

endmodule

bind ray_sphere_intersect rsi_checker #(.FRAC_BITS(FRAC_BITS)) u_rsi_checker (.*);

/* sim/ray_sphere_intersect_tb.sv */
// Self-checking testbench for the ray / sphere intersection unit.
`timescale 1ns / 1ps
module ray_sphere_intersect_tb;
    import rsi_pkg::*;

    localparam int FB        = DEF_FRAC_BITS;
    localparam int N_RANDOM  = 1625;
    localparam int MAX_CYC   = 400000;
    localparam int DRAIN_CYC = 400;     // well past the pipeline depth
    localparam int N_ROWS    = 12;
    localparam logic signed [WORD_BITS-1:0] ONE = 1 <<< FB;
    localparam logic signed [WORD_BITS-1:0] MISS_T = -ONE;

    logic      clk;
    logic      rst_n;
    logic      ray_valid;
    logic      ray_stall;
    rsi_in_t   ray_data;
    logic      hit_valid;
    logic      hit_stall;
    rsi_out_t  hit_data;

    ray_sphere_intersect DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .ray_valid (ray_valid),
        .ray_stall (ray_stall),
        .ray_data  (ray_data),
        .hit_valid (hit_valid),
        .hit_stall (hit_stall),
        .hit_data  (hit_data)
    );

    // 4 ns period
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Results still owed by the unit, oldest first.
    rsi_out_t expected_hits[$];
    int       mismatches = 0;
    int       rays_sent;
    int       cycles = 0;
    int       hold_left;     // short receiver stall, redrawn per transfer
    logic     long_hold;     // set by the pressure process
    logic     rx_took;       // a result transfer happened at the last edge

    // Nearer root of the ray / sphere quadratic, computed exactly on wide
    // vectors. Using h = oc.d (half of b) and Q = h*h - a*c (disc / 4), the
    // root is floor((-h*2^FB - floor(sqrt(Q*2^2FB))) / a).
    function automatic rsi_out_t nearest_root(rsi_in_t r);
        logic signed [255:0] ocx, ocy, ocz, dx, dy, dz, rad;
        logic signed [255:0] a, h, c, q, t, s, cand, n, quo;
        rsi_out_t res;
        ocx = $signed(r.origin_x) - $signed(r.center_x);
        ocy = $signed(r.origin_y) - $signed(r.center_y);
        ocz = $signed(r.origin_z) - $signed(r.center_z);
        dx  = $signed(r.dir_x);
        dy  = $signed(r.dir_y);
        dz  = $signed(r.dir_z);
        rad = {225'b0, r.sphere_radius};
        a = dx * dx + dy * dy + dz * dz;
        h = ocx * dx + ocy * dy + ocz * dz;
        c = ocx * ocx + ocy * ocy + ocz * ocz - rad * rad;
        q = h * h - a * c;
        res.hit_distance = MISS_T;
        res.is_hit       = 1'b0;
        if (a == 0 || q < 0)
            return res;
        t = q <<< (2 * FB);
        s = '0;
        for (int i = 127; i >= 0; i--)
        begin
            cand = s | (256'sd1 <<< i);
            if (cand * cand <= t)
                s = cand;
        end
        n = -(h <<< FB) - s;
        if (n < 0)
        begin
            // floor of a negative quotient: minus the ceiling of |n| / a
            quo = (-n + a - 1) / a;
            if (quo > (256'sd1 <<< (WORD_BITS - 1)))
                res.hit_distance = WORD_MIN;
            else
                res.hit_distance = -quo[WORD_BITS-1:0];
        end
        else
        begin
            quo = n / a;
            if (quo > $signed({224'b0, WORD_MAX}))
                res.hit_distance = WORD_MAX;
            else
                res.hit_distance = quo[WORD_BITS-1:0];
        end
        res.is_hit = 1'b1;
        return res;
    endfunction

    function automatic rsi_in_t mk_ray(
        logic signed [31:0] ox, oy, oz, dx, dy, dz, cx, cy, cz,
        logic [30:0] rad);
        rsi_in_t r;
        r.origin_x = ox;  r.origin_y = oy;  r.origin_z = oz;
        r.dir_x    = dx;  r.dir_y    = dy;  r.dir_z    = dz;
        r.center_x = cx;  r.center_y = cy;  r.center_z = cz;
        r.sphere_radius = rad;
        return r;
    endfunction

    // Uniform raw value in [-span, span].
    function automatic logic signed [31:0] near_zero(int unsigned span);
        return $signed($urandom_range(0, 2 * span)) - $signed(span);
    endfunction

    function automatic rsi_in_t random_ray();
        rsi_in_t      r;
        logic [319:0] noise;
        int unsigned  kind;
        kind = $urandom_range(0, 19);
        if (kind < 3)
        begin
            // raw noise over every bit
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom};
            r = noise[318:0];
        end
        else if (kind < 5)
        begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom};
            r = noise[318:0];
            r.dir_x = '0;
            r.dir_y = '0;
            r.dir_z = '0;
        end
        else
        begin
            // scene-like rays: modest coordinates, plenty of hits
            r = mk_ray(near_zero(64 << FB), near_zero(64 << FB), near_zero(64 << FB),
                       near_zero(4 << FB), near_zero(4 << FB), near_zero(4 << FB),
                       near_zero(32 << FB), near_zero(32 << FB), near_zero(32 << FB),
                       31'($urandom_range(0, 48 << FB)));
            if (kind == 19)
            begin
                // tiny direction, big sphere: roots run out of range
                r.dir_x = near_zero(2);
                r.dir_y = near_zero(2);
                r.dir_z = near_zero(2);
                r.sphere_radius = 31'($urandom) | 31'h4000_0000;
            end
        end
        return r;
    endfunction

    // Offer one ray after a gap, hold it until taken, then log its result.
    task automatic send_ray(rsi_in_t r, rsi_out_t want, int unsigned gap);
        if (gap > 0)
        begin
            ray_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        ray_valid <= 1'b1;
        ray_data  <= r;
        do
            @(posedge clk);
        while (ray_stall);
        expected_hits.push_back(want);
        rays_sent++;
        @(negedge clk);
    endtask

    // Gap ahead of the next ray; some long runs go back to back.
    function automatic int unsigned tx_gap();
        if (rays_sent % 200 < 60)
            return 0;
        return $urandom_range(0, 5);
    endfunction

    // Stimulus
    rsi_in_t  dir_rays[N_ROWS];
    rsi_out_t dir_want[N_ROWS];
    logic     dir_typed[N_ROWS];

    initial
    begin
        rst_n     = 1'b0;
        ray_valid = 1'b0;
        ray_data  = '0;
        rays_sent = 0;

        // directed rows; typed results where the geometry makes them obvious
        dir_rays[0]  = mk_ray(0, 0, 0, 0, 0, 0, 5 * ONE, 0, 0, ONE);        // zero direction
        dir_rays[1]  = mk_ray(0, 0, 0, ONE, 0, 0, 5 * ONE, 0, 0, ONE);      // hit at 4.0
        dir_rays[2]  = mk_ray(0, 0, 0, ONE, 0, 0, 5 * ONE, 5 * ONE, 0, ONE); // clean miss
        dir_rays[3]  = mk_ray(0, 0, 0, -ONE, 0, 0, 5 * ONE, 0, 0, ONE);     // sphere behind
        dir_rays[4]  = mk_ray(0, 0, 0, ONE, 0, 0, 0, 0, 0, 2 * ONE);        // origin inside
        dir_rays[5]  = mk_ray(0, 0, 0, ONE, 0, 0, 5 * ONE, ONE, 0, ONE);    // grazing
        dir_rays[6]  = mk_ray(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                              WORD_MAX, WORD_MAX, WORD_MAX, '1);
        dir_rays[7]  = mk_ray(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                              WORD_MIN, WORD_MIN, WORD_MIN, '0);
        dir_rays[8]  = mk_ray(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX,
                              WORD_MAX, WORD_MAX, WORD_MAX, '1);
        dir_rays[9]  = mk_ray(0, 0, 0, 1, 0, 0, 0, 0, 0, '1);              // saturates low
        dir_rays[10] = mk_ray(0, 0, 0, 1, 0, 0, WORD_MAX, 0, 0, '1);
        dir_rays[11] = mk_ray(-1, -1, -1, 1, 1, 1, 0, 0, 0, '0);

        for (int i = 0; i < N_ROWS; i++)
            dir_typed[i] = 1'b0;
        dir_want[0] = '{hit_distance: MISS_T, is_hit: 1'b0};
        dir_want[1] = '{hit_distance: 4 * ONE, is_hit: 1'b1};
        dir_want[2] = '{hit_distance: MISS_T, is_hit: 1'b0};
        dir_want[3] = '{hit_distance: -6 * ONE, is_hit: 1'b1};
        dir_want[4] = '{hit_distance: -2 * ONE, is_hit: 1'b1};
        dir_want[5] = '{hit_distance: 5 * ONE, is_hit: 1'b1};
        dir_want[9] = '{hit_distance: WORD_MIN, is_hit: 1'b1};
        for (int i = 0; i <= 5; i++)
            dir_typed[i] = 1'b1;
        dir_typed[9] = 1'b1;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_ROWS; i++)
            send_ray(dir_rays[i],
                     dir_typed[i] ? dir_want[i] : nearest_root(dir_rays[i]),
                     $urandom_range(0, 5));

        for (int i = 0; i < N_RANDOM; i++)
        begin
            rsi_in_t r;
            r = random_ray();
            send_ray(r, nearest_root(r), tx_gap());
        end
        ray_valid <= 1'b0;

        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (mismatches == 0)
            $display("[ray_sphere_intersect] OK");
        else
            $display("[ray_sphere_intersect] ERROR");
        $finish;
    end

    // Receiver: a short random stall after every transfer, with calm stretches.
    initial
    begin
        hit_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (rx_took === 1'b1)
                hold_left = ((rays_sent % 300) < 80) ? 0 : $urandom_range(0, 5);
            else if (hold_left > 0)
                hold_left = hold_left - 1;
            hit_stall <= long_hold || hold_left > 0;
        end
    end

    // Pressure: hold the output for a long stretch while rays keep coming,
    // so the pipeline and skid register fill and the input stalls.
    initial
    begin
        long_hold = 1'b0;
        wait (rays_sent >= 400);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (600) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Checker
    always @(posedge clk)
    begin
        rx_took <= rst_n && hit_valid && !hit_stall;
        if (rst_n && hit_valid && !hit_stall)
        begin
            if (expected_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: hit_distance %h is_hit %b",
                             hit_data.hit_distance, hit_data.is_hit);
            end
            else
            begin
                rsi_out_t want;
                want = expected_hits.pop_front();
                if (hit_data.hit_distance !== want.hit_distance
                    || hit_data.is_hit !== want.is_hit)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: hit_distance exp %h got %h, is_hit exp %b got %b",
                                 want.hit_distance, hit_data.hit_distance,
                                 want.is_hit, hit_data.is_hit);
                end
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYC)
        begin
            $display("[ray_sphere_intersect] ERROR");
            $finish;
        end
    end

endmodule
